@@ hw/rtl/bpa_pkg.sv @@
// shared constants and bitmap helpers of the buddy page allocator
package bpa_pkg;

  localparam int unsigned NUM_SLOTS_DEF   = 16;
  localparam int unsigned PAGES_PER_CHUNK = 128;
  localparam int unsigned MAX_ORDER       = 6;
  localparam int unsigned WORDS_PER_SLOT  = 4;
  localparam int unsigned ORD_W           = 3;
  localparam int unsigned IDX_W           = 7;
  localparam int unsigned FLAG_W          = 8;
  localparam logic [4:0]  KEEP_RESET      = 5'd2;
  localparam logic [2:0]  ORD_TOP         = 3'd6;
  localparam logic [1:0]  TOP_WORD        = 2'd3;
  // request kinds carried on tuser
  localparam logic        KIND_ALLOC      = 1'b0;
  localparam logic        KIND_FREE       = 1'b1;
  // order 6 block 1 sits at bitmap position 253, word 3
  localparam logic [63:0] ACT_WORD3       = 64'h2000_0000_0000_0000;

  // first bitmap position of each order
  function automatic logic [7:0] ord_base(input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = 8'd0;
      3'd1:    b = 8'd128;
      3'd2:    b = 8'd192;
      3'd3:    b = 8'd224;
      3'd4:    b = 8'd240;
      3'd5:    b = 8'd248;
      default: b = 8'd252;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] bit_pos(input logic [2:0] k, input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] m;
    m = IDX_W'(7'h7f >> k);
    return ord_base(k) + {1'b0, idx & m};
  endfunction

  // bits of the order's field within the word that holds it
  function automatic logic [63:0] field_mask(input logic [2:0] k);
    logic [63:0] m;
    unique case (k)
      3'd0, 3'd1: m = '1;
      3'd2:       m = 64'h0000_0000_ffff_ffff;
      3'd3:       m = 64'h0000_ffff_0000_0000;
      3'd4:       m = 64'h00ff_0000_0000_0000;
      3'd5:       m = 64'h0f00_0000_0000_0000;
      default:    m = 64'h3000_0000_0000_0000;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] lowest_bit(input logic [63:0] d);
    logic [5:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (d[i]) r = 6'(i);
    end
    return r;
  endfunction

  // per-slot summary: word0 any, word1 any, then orders 1 to 6 any
  function automatic logic [FLAG_W-1:0] upd_flags(input logic [FLAG_W-1:0] f,
                                                  input logic [1:0] w,
                                                  input logic [63:0] d);
    logic [FLAG_W-1:0] r;
    r = f;
    unique case (w)
      2'd0: r[0] = |d;
      2'd1: r[1] = |d;
      2'd2: r[2] = |d;
      default: begin
        r[3] = |d[31:0];
        r[4] = |d[47:32];
        r[5] = |d[55:48];
        r[6] = |d[59:56];
        r[7] = |d[61:60];
      end
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/buddy_page_allocator_core.sv @@
// buddy page allocator: bitmap memory, slot search and split/merge sequencer
// allocate: search, a take or 4 activation writes, then a read-modify-write per
//   split order, ending after the search when no slot is left; free: one
// read-modify-write per merged order; order seven or a bad slot goes to the result
// throughput: one request at a time, the next is taken the cycle after the result loads
// reset: slots inactive, count zero, keep_chunks 2; bitmap words are rewritten on activation
module buddy_page_allocator_core #(
  parameter int unsigned NUM_SLOTS = bpa_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // order[2:0], chunk_slot[6:3], page_offset[13:7]
  input  logic        s_axis_tuser_i,  // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // ok[0], result_slot[4:1], result_page[11:5],
                                       // slot_created[12], slot_released[13]
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned AW = SW + 2;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned FW = bpa_pkg::FLAG_W;
  localparam int unsigned IW = bpa_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_ACT, S_RD, S_MOD, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    STEP_TAKE, STEP_SPLIT, STEP_FREE
  } step_e;

  state_e          state_q;
  step_e           step_q;
  logic [4:0]      keep_q;
  logic [NUM_SLOTS-1:0] active_q;
  logic [CW-1:0]   count_q;
  logic [FW-1:0]   flags_q [NUM_SLOTS];
  logic [63:0]     mem_q [NUM_SLOTS*4];
  logic [63:0]     rdata_q;

  logic [SW-1:0]   slot_q;
  logic [2:0]      ord_q;
  logic [2:0]      from_q;
  logic [IW-1:0]   idx_q;
  logic [1:0]      take_word_q;
  logic [1:0]      wcnt_q;
  logic            first_q;
  logic            kind_q;
  logic            res_ok_q;
  logic            res_created_q;
  logic            res_released_q;
  logic            m_valid_q;
  logic [15:0]     m_data_q;

  // input fields
  logic [2:0]      in_ord;
  logic [3:0]      in_slot;
  logic [IW-1:0]   in_page;
  logic [SW-1:0]   in_slot_w;
  logic            in_slot_ok;

  assign in_ord    = s_axis_tdata_i[2:0];
  assign in_slot   = s_axis_tdata_i[6:3];
  assign in_page   = s_axis_tdata_i[13:7];
  assign in_slot_w = SW'(in_slot);
  assign in_slot_ok = (7'(in_slot) < 7'(NUM_SLOTS)) && active_q[in_slot_w];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // lowest order, then lowest slot that can supply the block
  logic            hit;
  logic [SW-1:0]   hit_slot;
  logic [2:0]      hit_ord;
  logic [1:0]      hit_word;
  logic [SW-1:0]   idle_slot;
  logic            any_k;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    hit_ord  = '0;
    hit_word = '0;
    any_k    = 1'b0;
    for (int k = 6; k >= 0; k--) begin
      for (int s = int'(NUM_SLOTS) - 1; s >= 0; s--) begin
        any_k = (k == 0) ? (flags_q[s][0] | flags_q[s][1]) : flags_q[s][k+1];
        if ((3'(k) >= ord_q) && active_q[s] && any_k) begin
          hit      = 1'b1;
          hit_slot = SW'(s);
          hit_ord  = 3'(k);
          // order 0 spans words 0 and 1, order 1 fills word 2, the rest share word 3
          if (k == 0) begin
            hit_word = flags_q[s][0] ? 2'd0 : 2'd1;
          end else if (k == 1) begin
            hit_word = 2'd2;
          end else begin
            hit_word = bpa_pkg::TOP_WORD;
          end
        end
      end
    end
    idle_slot = '0;
    for (int s = int'(NUM_SLOTS) - 1; s >= 0; s--) begin
      if (!active_q[s]) idle_slot = SW'(s);
    end
  end

  // target bit of the current read-modify-write
  logic [2:0]      tgt_ord;
  logic [IW-1:0]   tgt_idx;
  logic [7:0]      own_pos;
  logic [7:0]      bud_pos;
  logic [1:0]      rd_word;
  logic            own_set;
  logic            bud_set;
  logic [5:0]      take_bit;
  logic [7:0]      take_pos;
  logic [IW-1:0]   take_idx;
  logic            release_now;

  always_comb begin
    unique case (step_q)
      STEP_SPLIT: begin
        tgt_ord = from_q - 3'd1;
        tgt_idx = {idx_q[IW-2:0], 1'b1};
      end
      default: begin
        tgt_ord = from_q;
        tgt_idx = idx_q;
      end
    endcase
    own_pos  = bpa_pkg::bit_pos(tgt_ord, tgt_idx);
    bud_pos  = bpa_pkg::bit_pos(tgt_ord, tgt_idx ^ IW'(1));
    rd_word  = (step_q == STEP_TAKE) ? take_word_q : own_pos[7:6];
    own_set  = rdata_q[own_pos[5:0]];
    bud_set  = rdata_q[bud_pos[5:0]];
    take_bit = bpa_pkg::lowest_bit(rdata_q & bpa_pkg::field_mask(from_q));
    take_pos = {take_word_q, take_bit};
    take_idx = IW'(take_pos - bpa_pkg::ord_base(from_q));
    release_now = (from_q == bpa_pkg::ORD_TOP) && bud_set
                  && (8'(count_q) > 8'(keep_q));
  end

  // result word and output register load
  logic [15:0]     res_data;
  logic            out_load;

  always_comb begin
    res_data    = '0;
    res_data[0] = res_ok_q;
    if ((kind_q == bpa_pkg::KIND_ALLOC) && res_ok_q) begin
      res_data[4:1]  = 4'(slot_q);
      res_data[11:5] = IW'(idx_q << ord_q);
      res_data[12]   = res_created_q;
    end
    res_data[13] = res_released_q;
    out_load = (state_q == S_FIN) && (!m_valid_q || m_axis_tready_i);
  end

  // memory write port
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [63:0]     mem_wdata;
  logic [AW-1:0]   mem_raddr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {slot_q, rd_word};
    mem_wdata = rdata_q;
    mem_raddr = {slot_q, rd_word};
    if (state_q == S_ACT) begin
      mem_we    = 1'b1;
      mem_waddr = {slot_q, wcnt_q};
      mem_wdata = (wcnt_q == bpa_pkg::TOP_WORD) ? bpa_pkg::ACT_WORD3 : '0;
    end else if (state_q == S_MOD) begin
      unique case (step_q)
        STEP_TAKE: begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q & ~(64'd1 << take_bit);
        end
        STEP_SPLIT: begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q | (64'd1 << own_pos[5:0]);
        end
        default: begin
          mem_we = !(first_q && own_set) && !release_now;
          if ((from_q != bpa_pkg::ORD_TOP) && bud_set) begin
            mem_wdata = rdata_q & ~(64'd1 << bud_pos[5:0]);
          end else begin
            mem_wdata = rdata_q | (64'd1 << own_pos[5:0]);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      step_q         <= STEP_TAKE;
      keep_q         <= bpa_pkg::KEEP_RESET;
      active_q       <= '0;
      count_q        <= '0;
      for (int s = 0; s < int'(NUM_SLOTS); s++) flags_q[s] <= '0;
      m_valid_q      <= 1'b0;
      m_data_q       <= '0;
      slot_q         <= '0;
      ord_q          <= '0;
      from_q         <= '0;
      idx_q          <= '0;
      take_word_q    <= '0;
      wcnt_q         <= '0;
      first_q        <= 1'b0;
      kind_q         <= 1'b0;
      res_ok_q       <= 1'b0;
      res_created_q  <= 1'b0;
      res_released_q <= 1'b0;
    end else begin
      if (cfg_we_i) keep_q <= cfg_wdata_i;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      // keep the per-slot summary in step with every bitmap write
      if (mem_we) begin
        for (int s = 0; s < int'(NUM_SLOTS); s++) begin
          if (SW'(s) == slot_q) begin
            flags_q[s] <= bpa_pkg::upd_flags(flags_q[s], mem_waddr[1:0], mem_wdata);
          end
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            kind_q         <= s_axis_tuser_i;
            ord_q          <= in_ord;
            from_q         <= in_ord;
            slot_q         <= in_slot_w;
            idx_q          <= in_page >> in_ord;
            first_q        <= 1'b1;
            res_ok_q       <= 1'b0;
            res_created_q  <= 1'b0;
            res_released_q <= 1'b0;
            if (in_ord > bpa_pkg::ORD_TOP) begin
              state_q <= S_FIN;
            end else if (s_axis_tuser_i == bpa_pkg::KIND_ALLOC) begin
              state_q <= S_SEARCH;
            end else if (in_slot_ok) begin
              step_q  <= STEP_FREE;
              state_q <= S_RD;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            slot_q      <= hit_slot;
            from_q      <= hit_ord;
            take_word_q <= hit_word;
            step_q      <= STEP_TAKE;
            state_q     <= S_RD;
          end else if (8'(count_q) < 8'(NUM_SLOTS)) begin
            slot_q              <= idle_slot;
            active_q[idle_slot] <= 1'b1;
            count_q             <= count_q + CW'(1);
            from_q              <= bpa_pkg::ORD_TOP;
            idx_q               <= '0;
            wcnt_q              <= '0;
            res_created_q       <= 1'b1;
            state_q             <= S_ACT;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_ACT: begin
          wcnt_q <= wcnt_q + 2'd1;
          if (wcnt_q == bpa_pkg::TOP_WORD) begin
            res_ok_q <= 1'b1;
            step_q   <= STEP_SPLIT;
            state_q  <= (from_q > ord_q) ? S_RD : S_FIN;
          end
        end
        S_RD: begin
          state_q <= S_MOD;
        end
        S_MOD: begin
          unique case (step_q)
            STEP_TAKE: begin
              res_ok_q <= 1'b1;
              idx_q    <= take_idx;
              step_q   <= STEP_SPLIT;
              state_q  <= (from_q > ord_q) ? S_RD : S_FIN;
            end
            STEP_SPLIT: begin
              from_q  <= tgt_ord;
              idx_q   <= {idx_q[IW-2:0], 1'b0};
              state_q <= (tgt_ord > ord_q) ? S_RD : S_FIN;
            end
            default: begin
              first_q <= 1'b0;
              if (first_q && own_set) begin
                state_q <= S_FIN;
              end else begin
                res_ok_q <= 1'b1;
                if (release_now) begin
                  active_q[slot_q] <= 1'b0;
                  count_q          <= count_q - CW'(1);
                  res_released_q   <= 1'b1;
                  for (int s = 0; s < int'(NUM_SLOTS); s++) begin
                    if (SW'(s) == slot_q) flags_q[s] <= '0;
                  end
                  state_q <= S_FIN;
                end else if ((from_q != bpa_pkg::ORD_TOP) && bud_set) begin
                  idx_q   <= idx_q >> 1;
                  from_q  <= from_q + 3'd1;
                  state_q <= S_RD;
                end else begin
                  state_q <= S_FIN;
                end
              end
            end
          endcase
        end
        default: begin
          if (out_load) begin
            m_data_q <= res_data;
            state_q  <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(active_q) == int'(count_q))
    else $error("active count differs from active slots");

  a_rd_then_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |=> state_q == S_MOD)
    else $error("read not followed by modify");

  a_created_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_data_q[12] || m_data_q[13]) |-> m_data_q[0])
    else $error("slot change reported without ok");
`endif

endmodule

@@ tb/tb_buddy_page_allocator_core.sv @@
// testbench for the buddy page allocator core: random and directed allocate/free traffic
`timescale 1ns / 100ps

module tb_buddy_page_allocator_core;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic       released;
    logic       created;
    logic [6:0] page;
    logic [3:0] slot;
    logic       ok;
  } alloc_res_t;

  typedef struct {
    logic [3:0] slot;
    logic [6:0] page;
    logic [2:0] ord;
  } block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;

  buddy_page_allocator_core uut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .s_axis_tuser_i, .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state: one free bit per order and block index
  logic [127:0] free_map [NSLOT][7];
  logic         active [NSLOT];
  int           active_cnt;
  int           keep_cnt;
  alloc_res_t   pending_q[$];
  block_t       owned_q[$];
  int           errors = 0;
  int           n_sent = 0;
  int           n_checked = 0;
  int           n_created = 0;
  int           n_released = 0;
  int           stall_left = 0;

  function automatic int lowest_set(int s, int k);
    for (int i = 0; i < (128 >> k); i++) if (free_map[s][k][i]) return i;
    return -1;
  endfunction

  function automatic alloc_res_t predict_alloc(int ord);
    alloc_res_t r;
    int slot, idx, from, f;
    bit found;
    r = '0;
    found = 0;
    slot = 0; idx = 0; from = 0;
    for (int k = ord; k <= 6 && !found; k++)
      for (int s = 0; s < NSLOT && !found; s++)
        if (active[s]) begin
          f = lowest_set(s, k);
          if (f >= 0) begin
            found = 1; slot = s; idx = f; from = k;
          end
        end
    if (found) free_map[slot][from][idx] = 1'b0;
    else begin
      for (int s = 0; s < NSLOT && !found; s++)
        if (!active[s]) begin found = 1; slot = s; end
      if (!found) return r;
      active[slot] = 1'b1;
      active_cnt++;
      for (int k = 0; k < 7; k++) free_map[slot][k] = '0;
      free_map[slot][6][1] = 1'b1;
      idx = 0; from = 6;
      r.created = 1'b1;
    end
    while (from > ord) begin
      from--;
      idx = idx * 2;
      free_map[slot][from][idx + 1] = 1'b1;
    end
    r.ok = 1'b1;
    r.slot = slot[3:0];
    r.page = 7'(idx << ord);
    return r;
  endfunction

  function automatic alloc_res_t predict_free(int ord, int slot, int page);
    alloc_res_t r;
    int idx;
    r = '0;
    if (!active[slot]) return r;
    idx = page >> ord;
    if (free_map[slot][ord][idx]) return r;
    r.ok = 1'b1;
    forever begin
      if (ord == 6) begin
        if (free_map[slot][6][idx ^ 1] && active_cnt > keep_cnt) begin
          for (int k = 0; k < 7; k++) free_map[slot][k] = '0;
          active[slot] = 1'b0;
          active_cnt--;
          r.released = 1'b1;
        end else free_map[slot][6][idx] = 1'b1;
        return r;
      end
      if (free_map[slot][ord][idx ^ 1]) begin
        free_map[slot][ord][idx ^ 1] = 1'b0;
        idx = idx >> 1;
        ord++;
      end else begin
        free_map[slot][ord][idx] = 1'b1;
        return r;
      end
    end
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sends one request and queues its predicted result
  task automatic send_request(logic kind, logic [2:0] ord, logic [3:0] slot, logic [6:0] page);
    alloc_res_t r;
    repeat (rand_gap() + 1) @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {2'b00, page, slot, ord};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (ord == 3'd7) r = '0;
    else if (kind == bpa_pkg::KIND_ALLOC) r = predict_alloc(ord);
    else r = predict_free(ord, slot, page);
    if (kind == bpa_pkg::KIND_ALLOC && r.ok) begin
      owned_q.push_back('{slot: r.slot, page: r.page, ord: ord});
    end
    pending_q.push_back(r);
    n_sent++;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic write_keep(int v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 5'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    keep_cnt = v;
  endtask

  // free one owned block, picked at random
  task automatic free_owned();
    int i;
    block_t b;
    i = $urandom_range(0, owned_q.size() - 1);
    b = owned_q[i];
    owned_q.delete(i);
    send_request(bpa_pkg::KIND_FREE, b.ord, b.slot, b.page);
  endtask

  // result side: stalls of random length, compare against oldest prediction
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = rand_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    alloc_res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = alloc_res_t'(m_axis_tdata_o[13:0]);
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (want.created) n_created++;
        if (want.released) n_released++;
        if (got.ok !== want.ok)
          $display("%0t: ok exp %0d got %0d", $time, want.ok, got.ok);
        if (got.slot !== want.slot)
          $display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
        if (got.page !== want.page)
          $display("%0t: page exp %0d got %0d", $time, want.page, got.page);
        if (got.created !== want.created)
          $display("%0t: created exp %0d got %0d", $time, want.created, got.created);
        if (got.released !== want.released)
          $display("%0t: released exp %0d got %0d", $time, want.released, got.released);
        if (got !== want) errors++;
        if (m_axis_tdata_o[15:14] !== 2'b00) begin
          $display("%0t: pad bits exp 0 got %b", $time, m_axis_tdata_o[15:14]);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    // every order, order seven, bad frees, double free, misaligned, full merge
    for (int k = 0; k <= 7; k++) send_request(bpa_pkg::KIND_ALLOC, 3'(k), 4'd0, 7'd0);
    send_request(bpa_pkg::KIND_FREE, 3'd0, 4'd15, 7'd127);
    send_request(bpa_pkg::KIND_FREE, 3'd7, 4'd0, 7'd0);
    send_request(bpa_pkg::KIND_FREE, 3'd1, 4'd0, 7'd0);
    send_request(bpa_pkg::KIND_FREE, 3'd1, 4'd0, 7'd0);
    send_request(bpa_pkg::KIND_FREE, 3'd2, 4'd0, 7'd5);
    while (owned_q.size() != 0) free_owned();
  endtask

  task automatic test_exhaust();
    // fill all slots, fail one more, then free everything
    write_keep(0);
    for (int i = 0; i < 2 * NSLOT; i++) send_request(bpa_pkg::KIND_ALLOC, 3'd6, 4'd0, 7'd0);
    send_request(bpa_pkg::KIND_ALLOC, 3'd0, 4'd0, 7'd0);
    wait_drained();
    while (owned_q.size() != 0) free_owned();
    write_keep(16);
  endtask

  task automatic test_random(int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 45 || owned_q.size() == 0)
        send_request(bpa_pkg::KIND_ALLOC, 3'($urandom_range(0, 6)), 4'($urandom),
                     7'($urandom));
      else if (p < 92) free_owned();
      else send_request(1'($urandom), 3'($urandom), 4'($urandom), 7'($urandom));
      if (owned_q.size() > 120) while (owned_q.size() > 20) free_owned();
    end
  endtask

  initial begin
    for (int s = 0; s < NSLOT; s++) begin
      active[s] = 1'b0;
      for (int k = 0; k < 7; k++) free_map[s][k] = '0;
    end
    active_cnt = 0;
    keep_cnt = 2;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_exhaust();
    test_random(400);
    write_keep(1);
    test_random(400);
    write_keep(31);
    test_random(300);
    write_keep(0);
    test_random(400);
    wait_drained();
    $display("covered %0d requests, %0d results checked", n_sent, n_checked);
    $display("slots activated %0d times, released %0d times", n_created, n_released);
    if (errors == 0 && pending_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ buddy_page_allocator_core.f @@
hw/rtl/bpa_pkg.sv
hw/rtl/buddy_page_allocator_core.sv
tb/tb_buddy_page_allocator_core.sv
